// ===== sv/glf_pkg.sv =====
// ----------------------------------------------------------------------------
// glf_pkg
// Shared constants, register indexes and helper functions for the binary64
// Gaussian log-density pipeline.
// ----------------------------------------------------------------------------
package glf_pkg;

   // pipeline depths of the arithmetic units
   localparam int ADD_LAT    = 6;
   localparam int MUL_LAT    = 5;
   localparam int PIPE_DEPTH = 2 * ADD_LAT + 2 * MUL_LAT;

   localparam logic [63:0] NEG_INF_BITS   = 64'hFFF0_0000_0000_0000;
   localparam logic [63:0] CANON_NAN_BITS = 64'h7FF8_0000_0000_0000;
   localparam logic [10:0] EXP_ALL_ONES   = 11'h7FF;

   typedef enum logic [1:0] {
      CSR_MEAN_VALUE = 2'd0,
      CSR_QUAD_SCALE = 2'd1,
      CSR_LOG_OFFSET = 2'd2
   } csr_index_type;

   // leading zero count, 128 for an all-zero word
   function automatic logic [7:0] lzc128(input logic [127:0] v);
      logic [7:0] n;
      logic       hit;
      n   = 8'd128;
      hit = 1'b0;
      for (int i = 127; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n   = 8'(127 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic is_nan(input logic [63:0] b);
      return (b[62:52] == EXP_ALL_ONES) && (b[51:0] != 52'd0);
   endfunction

   function automatic logic is_inf(input logic [63:0] b);
      return (b[62:52] == EXP_ALL_ONES) && (b[51:0] == 52'd0);
   endfunction

endpackage

// ===== sv/gaussian_log_likelihood_fp64.sv =====
// ----------------------------------------------------------------------------
// gaussian_log_likelihood_fp64
// Binary64 Gaussian log-density: offset + (scale * (x - mean)) * (x - mean).
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one binary64 sample and a batch-end flag per item;
//   rsp channel returns the log-density bits and the copied flag.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low.
//   csr_write_en writes mean_value, quad_scale or log_offset (index 0..2);
//   other indexes are ignored. The user must write them only while no
//   item is in flight; the block itself does not enforce it.
// Pipeline: subtract, two multiplies, add and the output register.
//   One item per cycle while no result is stalled; the depth is set by
//   the binary64 adder and multiplier stages.
// Reset: synchronous; clears all valid bits and the three registers (+0.0).
// Stall: while a valid result is stalled the whole pipeline holds and
//   req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module gaussian_log_likelihood_fp64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_sample_bits,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_loglik_bits,
   output logic        rsp_last_result,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   localparam int DEPTH = glf_pkg::PIPE_DEPTH;
   localparam int MLAT  = glf_pkg::MUL_LAT;

   logic        advance;
   logic [63:0] mean_ff, scale_ff, offset_ff;
   logic [63:0] neg_mean, d_bits, p_bits, q_bits, r_bits;
   logic [63:0] d_dly_ff [MLAT];
   logic        vld_ff  [DEPTH];
   logic        last_ff [DEPTH];
   logic        bad_ff  [DEPTH];
   logic        rsp_valid_ff;
   logic [63:0] rsp_bits_ff, rsp_bits_in;
   logic        rsp_last_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff   <= 64'd0;
         scale_ff  <= 64'd0;
         offset_ff <= 64'd0;
      end else if (csr_write_en) begin
         case (glf_pkg::csr_index_type'(csr_index))
            glf_pkg::CSR_MEAN_VALUE: mean_ff   <= csr_write_data;
            glf_pkg::CSR_QUAD_SCALE: scale_ff  <= csr_write_data;
            glf_pkg::CSR_LOG_OFFSET: offset_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign neg_mean = {~mean_ff[63], mean_ff[62:0]};

   glf_fadd u_sub (
      .clock    (clock),
      .advance  (advance),
      .a_bits   (req_sample_bits),
      .b_bits   (neg_mean),
      .res_bits (d_bits)
   );

   glf_fmul u_mul_scale (
      .clock    (clock),
      .advance  (advance),
      .a_bits   (scale_ff),
      .b_bits   (d_bits),
      .res_bits (p_bits)
   );

   // deviation waits for the first product
   always_ff @(posedge clock) begin
      if (advance) begin
         d_dly_ff[0] <= d_bits;
         for (int i = 1; i < MLAT; i++) begin
            d_dly_ff[i] <= d_dly_ff[i-1];
         end
      end
   end

   glf_fmul u_mul_dev (
      .clock    (clock),
      .advance  (advance),
      .a_bits   (p_bits),
      .b_bits   (d_dly_ff[MLAT-1]),
      .res_bits (q_bits)
   );

   glf_fadd u_add_offset (
      .clock    (clock),
      .advance  (advance),
      .a_bits   (offset_ff),
      .b_bits   (q_bits),
      .res_bits (r_bits)
   );

   // item valid, batch flag and nan/inf sample flag ride along
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff[0] <= req_last_sample;
         bad_ff[0]  <= (req_sample_bits[62:52] == glf_pkg::EXP_ALL_ONES);
         for (int i = 1; i < DEPTH; i++) begin
            last_ff[i] <= last_ff[i-1];
            bad_ff[i]  <= bad_ff[i-1];
         end
      end
   end

   always_comb begin
      if (bad_ff[DEPTH-1]) begin
         rsp_bits_in = glf_pkg::NEG_INF_BITS;
      end else if (glf_pkg::is_nan(r_bits)) begin
         rsp_bits_in = glf_pkg::CANON_NAN_BITS;
      end else begin
         rsp_bits_in = r_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_bits_ff <= rsp_bits_in;
         rsp_last_ff <= last_ff[DEPTH-1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_loglik_bits = rsp_bits_ff;
   assign rsp_last_result = rsp_last_ff;

   // a stalled result freezes the first and last valid stages and the output valid
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff[DEPTH-1]) && $stable(vld_ff[0]) && $stable(rsp_valid_ff))
      else $error("pipeline moved while the result was stalled");

   // only the canonical nan ever leaves the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_bits_ff[62:52] == glf_pkg::EXP_ALL_ONES)
      && (rsp_bits_ff[51:0] != 52'd0) |-> rsp_bits_ff == glf_pkg::CANON_NAN_BITS)
      else $error("non-canonical nan on the result");

   // input stall follows the output register exactly
   assert property (@(posedge clock) req_stall == (rsp_valid_ff && rsp_stall))
      else $error("input stall out of step with output stall");

   // nothing comes out right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

// ===== sv/glf_fmul.sv =====
// ----------------------------------------------------------------------------
// glf_fmul
// Pipelined binary64 multiplier, round to nearest even, subnormals kept.
// Stages: partial products, product sum, leading zero count, normalize, round.
// ----------------------------------------------------------------------------
module glf_fmul (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] a_bits,
   input  logic [63:0] b_bits,
   output logic [63:0] res_bits
);

   // stage 1: unpack and partial products
   logic [10:0]        ea, eb, eap, ebp;
   logic [52:0]        ma, mb;
   logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
   logic [51:0]        pp_hh_in;
   logic [52:0]        pp_hl_in, pp_lh_in;
   logic [53:0]        pp_ll_in;
   logic signed [13:0] t_in;
   logic               nan1_in, inf1_in;

   logic [51:0]        pp_hh_ff;
   logic [52:0]        pp_hl_ff, pp_lh_ff;
   logic [53:0]        pp_ll_ff;
   logic signed [13:0] t1_ff;
   logic               sign1_ff, nan1_ff, inf1_ff;

   always_comb begin
      ea     = a_bits[62:52];
      eb     = b_bits[62:52];
      ma     = {ea != 11'd0, a_bits[51:0]};
      mb     = {eb != 11'd0, b_bits[51:0]};
      eap    = (ea == 11'd0) ? 11'd1 : ea;
      ebp    = (eb == 11'd0) ? 11'd1 : eb;
      a_zero = (a_bits[62:0] == 63'd0);
      b_zero = (b_bits[62:0] == 63'd0);
      a_inf  = glf_pkg::is_inf(a_bits);
      b_inf  = glf_pkg::is_inf(b_bits);
      a_nan  = glf_pkg::is_nan(a_bits);
      b_nan  = glf_pkg::is_nan(b_bits);
      pp_hh_in = ma[52:27] * mb[52:27];
      pp_hl_in = 53'(ma[52:27] * mb[26:0]);
      pp_lh_in = 53'(ma[26:0] * mb[52:27]);
      pp_ll_in = ma[26:0] * mb[26:0];
      t_in    = $signed({3'b0, eap}) + $signed({3'b0, ebp}) - 14'sd1022;
      nan1_in = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      inf1_in = (a_inf | b_inf) & ~nan1_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_hh_ff <= pp_hh_in;
         pp_hl_ff <= pp_hl_in;
         pp_lh_ff <= pp_lh_in;
         pp_ll_ff <= pp_ll_in;
         t1_ff    <= t_in;
         sign1_ff <= a_bits[63] ^ b_bits[63];
         nan1_ff  <= nan1_in;
         inf1_ff  <= inf1_in;
      end
   end

   // stage 2: sum of partial products
   logic [105:0]       prod_in;
   logic [105:0]       prod_ff;
   logic signed [13:0] t2_ff;
   logic               sign2_ff, nan2_ff, inf2_ff;

   assign prod_in = {pp_hh_ff, 54'd0} + {26'd0, pp_hl_ff, 27'd0}
                  + {26'd0, pp_lh_ff, 27'd0} + {52'd0, pp_ll_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         t2_ff    <= t1_ff;
         sign2_ff <= sign1_ff;
         nan2_ff  <= nan1_ff;
         inf2_ff  <= inf1_ff;
      end
   end

   // stage 3: leading zeros, shift amount and exponent
   logic [7:0]         lz;
   logic signed [13:0] lz_s, tm1, shl_in, be3_in;
   logic [105:0]       p3_ff;
   logic signed [13:0] shl_ff, be3_ff;
   logic               sign3_ff, nan3_ff, inf3_ff;

   always_comb begin
      lz     = glf_pkg::lzc128({prod_ff, {22{1'b1}}});
      lz_s   = $signed({6'd0, lz});
      tm1    = t2_ff - 14'sd1;
      // stop at the subnormal boundary, shift right when below it
      shl_in = (lz_s < tm1) ? lz_s : tm1;
      be3_in = t2_ff - shl_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_ff    <= prod_ff;
         shl_ff   <= shl_in;
         be3_ff   <= be3_in;
         sign3_ff <= sign2_ff;
         nan3_ff  <= nan2_ff;
         inf3_ff  <= inf2_ff;
      end
   end

   // stage 4: normalize
   logic [13:0]        neg_sh;
   logic [6:0]         rsc;
   logic [233:0]       wide;
   logic [105:0]       n4_in;
   logic               st4_in;
   logic [105:0]       n4_ff;
   logic               st4_ff;
   logic signed [13:0] be4_ff;
   logic               sign4_ff, nan4_ff, inf4_ff;

   always_comb begin
      neg_sh = 14'(-shl_ff);
      rsc    = (neg_sh > 14'd127) ? 7'd127 : neg_sh[6:0];
      wide   = {p3_ff, 128'd0} >> rsc;
      if (!shl_ff[13]) begin
         n4_in  = p3_ff << shl_ff[6:0];
         st4_in = 1'b0;
      end else begin
         n4_in  = wide[233:128];
         st4_in = |wide[127:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n4_ff    <= n4_in;
         st4_ff   <= st4_in;
         be4_ff   <= be3_ff;
         sign4_ff <= sign3_ff;
         nan4_ff  <= nan3_ff;
         inf4_ff  <= inf3_ff;
      end
   end

   // stage 5: round to nearest even
   logic [52:0] m53;
   logic        guard, sticky, inc, ovf;
   logic [10:0] ef;
   logic [62:0] rnd;
   logic [63:0] res_in;
   logic [63:0] res_ff;

   always_comb begin
      m53    = n4_ff[105:53];
      guard  = n4_ff[52];
      sticky = (|n4_ff[51:0]) | st4_ff;
      inc    = guard & (sticky | m53[0]);
      ef     = m53[52] ? be4_ff[10:0] : 11'd0;
      ovf    = m53[52] && (be4_ff > 14'sd2046);
      // a carry out of the fraction bumps the exponent, up to infinity
      rnd    = {ef, m53[51:0]} + {62'd0, inc};
      if (nan4_ff) begin
         res_in = glf_pkg::CANON_NAN_BITS;
      end else if (inf4_ff || ovf) begin
         res_in = {sign4_ff, glf_pkg::EXP_ALL_ONES, 52'd0};
      end else begin
         res_in = {sign4_ff, rnd};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign res_bits = res_ff;

endmodule

// ===== sv/glf_fadd.sv =====
// ----------------------------------------------------------------------------
// glf_fadd
// Pipelined binary64 adder, round to nearest even, subnormals kept.
// Stages: order operands, align, add, leading zero count, normalize, round.
// ----------------------------------------------------------------------------
module glf_fadd (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] a_bits,
   input  logic [63:0] b_bits,
   output logic [63:0] res_bits
);

   // stage 1: put the larger magnitude first
   logic        swap;
   logic [63:0] big, sml;
   logic [10:0] ebp, esp;
   logic        a_inf, b_inf, nan1_in;

   logic [52:0] mbig_ff, msml_ff;
   logic [10:0] d1_ff, e1_ff;
   logic        sign1_ff, sub1_ff, nan1_ff, inf1_ff;

   always_comb begin
      swap    = b_bits[62:0] > a_bits[62:0];
      big     = swap ? b_bits : a_bits;
      sml     = swap ? a_bits : b_bits;
      ebp     = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
      esp     = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
      a_inf   = glf_pkg::is_inf(a_bits);
      b_inf   = glf_pkg::is_inf(b_bits);
      nan1_in = glf_pkg::is_nan(a_bits) | glf_pkg::is_nan(b_bits)
              | (a_inf & b_inf & (a_bits[63] ^ b_bits[63]));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mbig_ff  <= {big[62:52] != 11'd0, big[51:0]};
         msml_ff  <= {sml[62:52] != 11'd0, sml[51:0]};
         d1_ff    <= ebp - esp;
         e1_ff    <= ebp;
         sign1_ff <= big[63];
         sub1_ff  <= a_bits[63] ^ b_bits[63];
         nan1_ff  <= nan1_in;
         inf1_ff  <= (a_inf | b_inf) & ~nan1_in;
      end
   end

   // stage 2: align the smaller operand, keep a sticky bit
   logic [5:0]   dc;
   logic [119:0] wide;
   logic [55:0]  bal_in;
   logic [55:0]  abig_ff, bal_ff;
   logic [10:0]  e2_ff;
   logic         sign2_ff, sub2_ff, nan2_ff, inf2_ff;

   always_comb begin
      dc     = (d1_ff > 11'd63) ? 6'd63 : d1_ff[5:0];
      wide   = {msml_ff, 3'd0, 64'd0} >> dc;
      bal_in = {wide[119:65], wide[64] | (|wide[63:0])};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         abig_ff  <= {mbig_ff, 3'd0};
         bal_ff   <= bal_in;
         e2_ff    <= e1_ff;
         sign2_ff <= sign1_ff;
         sub2_ff  <= sub1_ff;
         nan2_ff  <= nan1_ff;
         inf2_ff  <= inf1_ff;
      end
   end

   // stage 3: add or subtract
   logic [56:0] sum_in;
   logic [56:0] sum3_ff;
   logic [10:0] e3_ff;
   logic        sign3_ff, nan3_ff, inf3_ff;

   assign sum_in = sub2_ff ? ({1'b0, abig_ff} - {1'b0, bal_ff})
                           : ({1'b0, abig_ff} + {1'b0, bal_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         sum3_ff  <= sum_in;
         e3_ff    <= e2_ff;
         // exact cancellation gives +0
         sign3_ff <= sign2_ff & ~(sub2_ff && (sum_in == 57'd0));
         nan3_ff  <= nan2_ff;
         inf3_ff  <= inf2_ff;
      end
   end

   // stage 4: leading zeros, limited by the subnormal boundary
   logic [7:0]  lz;
   logic [10:0] shl_in;
   logic [56:0] sum4_ff;
   logic [5:0]  shl_ff;
   logic [11:0] be4_ff;
   logic        sign4_ff, nan4_ff, inf4_ff;

   always_comb begin
      lz     = glf_pkg::lzc128({sum3_ff, {71{1'b1}}});
      shl_in = ({3'd0, lz} < e3_ff) ? {3'd0, lz} : e3_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum4_ff  <= sum3_ff;
         shl_ff   <= shl_in[5:0];
         be4_ff   <= {1'b0, e3_ff} + 12'd1 - {1'b0, shl_in};
         sign4_ff <= sign3_ff;
         nan4_ff  <= nan3_ff;
         inf4_ff  <= inf3_ff;
      end
   end

   // stage 5: normalize
   logic [56:0] n5_ff;
   logic [11:0] be5_ff;
   logic        sign5_ff, nan5_ff, inf5_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         n5_ff    <= sum4_ff << shl_ff;
         be5_ff   <= be4_ff;
         sign5_ff <= sign4_ff;
         nan5_ff  <= nan4_ff;
         inf5_ff  <= inf4_ff;
      end
   end

   // stage 6: round to nearest even
   logic [52:0] m53;
   logic        guard, sticky, inc, ovf;
   logic [10:0] ef;
   logic [62:0] rnd;
   logic [63:0] res_in;
   logic [63:0] res_ff;

   always_comb begin
      m53    = n5_ff[56:4];
      guard  = n5_ff[3];
      sticky = |n5_ff[2:0];
      inc    = guard & (sticky | m53[0]);
      ef     = m53[52] ? be5_ff[10:0] : 11'd0;
      ovf    = m53[52] && (be5_ff > 12'd2046);
      rnd    = {ef, m53[51:0]} + {62'd0, inc};
      if (nan5_ff) begin
         res_in = glf_pkg::CANON_NAN_BITS;
      end else if (inf5_ff || ovf) begin
         res_in = {sign5_ff, glf_pkg::EXP_ALL_ONES, 52'd0};
      end else begin
         res_in = {sign5_ff, rnd};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign res_bits = res_ff;

endmodule
